// ===== hdl/btn_rpt_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Button auto-repeat package
// Shared constants, register indexes and types for the button auto-repeat
// unit and its per-button cell.
// ============================================================================
package btn_rpt_pkg;

    // Number of buttons handled by the unit.
    localparam int BUTTON_COUNT = 8;

    // Width of the level and event fields on the ports.
    localparam int FIELD_WIDTH = 8;

    // Buttons beyond the field width can never show up in the event mask, so
    // only the low ones get hardware.
    localparam int ACTIVE_COUNT = (BUTTON_COUNT < FIELD_WIDTH) ? BUTTON_COUNT : FIELD_WIDTH;

    localparam int TIME_WIDTH  = 32;
    localparam int DELAY_WIDTH = 16;
    localparam int INDEX_WIDTH = 8;

    // Reset values of the timing registers, in milliseconds.
    localparam logic [DELAY_WIDTH-1:0] INITIAL_DELAY_RESET = 16'd300;
    localparam logic [DELAY_WIDTH-1:0] REPEAT_PERIOD_RESET = 16'd100;

    // Configuration register indexes.
    typedef enum logic [INDEX_WIDTH-1:0] {
        CFG_INITIAL_DELAY = 8'd0,
        CFG_REPEAT_PERIOD = 8'd1
    } t_cfg_index;

    // Timing settings shared by all button cells.
    typedef struct packed {
        logic [DELAY_WIDTH-1:0] initial_delay_ms;
        logic [DELAY_WIDTH-1:0] repeat_period_ms;
    } t_timing;

endpackage : btn_rpt_pkg

// ===== hdl/btn_rpt_cell.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Button auto-repeat cell
// Edge detection and hold timing for one button. Produces a press event on
// a falling level, then repeat events after the initial delay and every
// repeat period while the button stays pressed.
// ============================================================================
module btn_rpt_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_level,
    input  logic [btn_rpt_pkg::TIME_WIDTH-1:0]  i_now_ms,
    input  btn_rpt_pkg::t_timing                i_timing,
    output logic                                o_fire
);
    import btn_rpt_pkg::*;

    logic                  r_prev;
    logic                  r_phase;
    logic [TIME_WIDTH-1:0] r_mark;
    logic                  n_prev;
    logic                  n_phase;
    logic [TIME_WIDTH-1:0] n_mark;
    logic [TIME_WIDTH-1:0] w_held;
    logic                  w_fire;

    // Held time uses wrap-around subtraction.
    assign w_held = i_now_ms - r_mark;

    // Event decision and next state for this sample.
    always_comb begin
        w_fire  = 1'b0;
        n_phase = r_phase;
        n_mark  = r_mark;
        n_prev  = i_level;
        if (!i_level) begin
            if (r_prev) begin
                w_fire  = 1'b1;
                n_phase = 1'b0;
            end else if (!r_phase &&
                         (w_held >= TIME_WIDTH'(i_timing.initial_delay_ms))) begin
                w_fire  = 1'b1;
                n_phase = 1'b1;
            end else if (r_phase &&
                         (w_held >= TIME_WIDTH'(i_timing.repeat_period_ms))) begin
                w_fire  = 1'b1;
            end
            if (w_fire) begin
                n_mark = i_now_ms;
            end
        end else begin
            n_phase = 1'b0;
        end
    end

    assign o_fire = w_fire;

    // Control state: the button starts released and outside the repeat phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 1'b1;
            r_phase <= 1'b0;
        end else if (i_en) begin
            r_prev  <= n_prev;
            r_phase <= n_phase;
        end
    end

    // The time mark is always written by a press before it is read.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mark <= n_mark;
        end
    end

endmodule : btn_rpt_cell

// ===== hdl/button_auto_repeat_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Button auto-repeat unit
// Turns samples of active-low button levels with a millisecond time stamp
// into a mask of press and auto-repeat events, one result beat per sample.
// ============================================================================
// Path: an accepted sample beat passes through the input register, then the
// per-button logic into the result beat on the output register.
// Throughput: 1 sample per cycle unless the output stalls; both registers advance
// together, so a full input register takes no sample while a result waits downstream.
// Reset: all buttons released and outside the repeat phase, no beats held,
// initial delay 300 ms and repeat period 100 ms.
module button_auto_repeat_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Sample channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [btn_rpt_pkg::FIELD_WIDTH-1:0]   i_button_levels,
    input  logic [btn_rpt_pkg::TIME_WIDTH-1:0]    i_now_ms,
    // Event channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [btn_rpt_pkg::FIELD_WIDTH-1:0]   o_event_mask,
    // Configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [btn_rpt_pkg::INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [btn_rpt_pkg::DELAY_WIDTH-1:0]   i_cfg_data
);
    import btn_rpt_pkg::*;

    t_timing                  r_timing;
    t_timing                  n_timing;
    logic                     r_s1_valid;
    logic [FIELD_WIDTH-1:0]   r_s1_levels;
    logic [TIME_WIDTH-1:0]    r_s1_now;
    logic                     r_out_valid;
    logic [FIELD_WIDTH-1:0]   r_out_mask;
    logic [FIELD_WIDTH-1:0]   n_event_mask;
    logic [ACTIVE_COUNT-1:0]  w_fire;
    logic                     w_s1_adv;
    logic                     w_in_acc;

    // Configuration registers: writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_timing = r_timing;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INITIAL_DELAY: n_timing.initial_delay_ms = i_cfg_data;
                CFG_REPEAT_PERIOD: n_timing.repeat_period_ms = i_cfg_data;
                default:           n_timing = r_timing;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.initial_delay_ms <= INITIAL_DELAY_RESET;
            r_timing.repeat_period_ms <= REPEAT_PERIOD_RESET;
        end else begin
            r_timing <= n_timing;
        end
    end

    // Handshake: the input stage moves when the output register is free or
    // being emptied in the same cycle.
    assign w_s1_adv   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_s1_adv;
    assign w_in_acc   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_levels <= i_button_levels;
            r_s1_now    <= i_now_ms;
        end
    end

    // One cell per button that can reach the event mask.
    for (genvar g = 0; g < ACTIVE_COUNT; g++) begin : g_cell
        btn_rpt_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_s1_adv),
            .i_level  (r_s1_levels[g]),
            .i_now_ms (r_s1_now),
            .i_timing (r_timing),
            .o_fire   (w_fire[g])
        );
    end

    assign n_event_mask = FIELD_WIDTH'(w_fire);

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_mask <= n_event_mask;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_mask = r_out_mask;

    // A sample held in the input stage is never dropped while the output stalls.
    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_adv) |=> r_s1_valid)
        else $error("input stage lost a sample while stalled");

    // An empty input stage always takes a sample.
    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_in_ready)
        else $error("input stage empty but not ready");

    // Every sample that moves on produces a result beat.
    a_adv_to_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv |=> r_out_valid)
        else $error("advanced sample produced no result beat");

    // Reset empties both stages.
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_valid && !r_out_valid))
        else $error("pipeline not empty after reset");

endmodule : button_auto_repeat_unit

// ===== test/button_auto_repeat_unit_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Button auto-repeat unit testbench
// Drives timed button samples through the unit under several timing settings
// and handshake stall patterns. A cycle-free predictor tracks each button's
// last level, time mark and repeat phase. Every event beat is checked against
// the oldest predicted mask.
// ============================================================================
module button_auto_repeat_unit_tb;

    import btn_rpt_pkg::*;

    // Register indexes that map to no register; writes to them must be dropped.
    localparam logic [INDEX_WIDTH-1:0] CFG_UNMAPPED_LOW  = 8'd2;
    localparam logic [INDEX_WIDTH-1:0] CFG_UNMAPPED_HIGH = 8'hFF;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_SAMPLES  = 115;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] levels;
        logic [TIME_WIDTH-1:0]  now;
    } t_sample;

    logic                   i_clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   o_in_ready;
    logic [FIELD_WIDTH-1:0] button_levels = '1;
    logic [TIME_WIDTH-1:0]  now_ms = '0;
    logic                   o_out_valid;
    logic                   out_ready = 1'b0;
    logic [FIELD_WIDTH-1:0] o_event_mask;
    logic                   cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [INDEX_WIDTH-1:0] cfg_index = '0;
    logic [DELAY_WIDTH-1:0] cfg_data = '0;

    t_sample                pending_samples[$];
    logic [FIELD_WIDTH-1:0] expected_masks[$];
    int                     mismatch_count = 0;
    int                     idle_cycles = 0;
    int                     sender_idle_pct = 0;
    int                     stall_pct = 0;

    // Predicted per-button state and the timing registers it runs with.
    t_timing                timing_now;
    logic                   last_level[ACTIVE_COUNT];
    logic [TIME_WIDTH-1:0]  mark_ms[ACTIVE_COUNT];
    logic                   in_repeat[ACTIVE_COUNT];

    // Random sequence state: buttons currently held and the running clock.
    logic [FIELD_WIDTH-1:0] held_buttons = '0;
    logic [TIME_WIDTH-1:0]  clock_ms = 32'hFFFF_F000;

    button_auto_repeat_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_button_levels (button_levels),
        .i_now_ms        (now_ms),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_event_mask    (o_event_mask),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Bring the predicted state to its power-up values.
    function automatic void clear_button_state();
        timing_now.initial_delay_ms = INITIAL_DELAY_RESET;
        timing_now.repeat_period_ms = REPEAT_PERIOD_RESET;
        for (int b = 0; b < ACTIVE_COUNT; b++) begin
            last_level[b] = 1'b1;
            mark_ms[b]    = '0;
            in_repeat[b]  = 1'b0;
        end
    endfunction

    // Advance every button by one sample and return the buttons that fire.
    function automatic logic [FIELD_WIDTH-1:0] predict_event_mask(
        input logic [FIELD_WIDTH-1:0] levels,
        input logic [TIME_WIDTH-1:0]  now
    );
        logic [FIELD_WIDTH-1:0] mask;
        logic [TIME_WIDTH-1:0]  held;
        logic                   fire;
        mask = '0;
        for (int b = 0; b < ACTIVE_COUNT; b++) begin
            if (!levels[b]) begin
                fire = 1'b0;
                if (last_level[b]) begin
                    // A fresh press always fires and starts the initial delay.
                    fire = 1'b1;
                    in_repeat[b] = 1'b0;
                end else begin
                    // Held time wraps modulo 2^32 with no saturation.
                    held = now - mark_ms[b];
                    if (!in_repeat[b] &&
                        held >= TIME_WIDTH'(timing_now.initial_delay_ms)) begin
                        fire = 1'b1;
                        in_repeat[b] = 1'b1;
                    end else if (in_repeat[b] &&
                                 held >= TIME_WIDTH'(timing_now.repeat_period_ms)) begin
                        fire = 1'b1;
                    end
                end
                if (fire) begin
                    mark_ms[b] = now;
                    mask[b] = 1'b1;
                end
            end else begin
                in_repeat[b] = 1'b0;
            end
            last_level[b] = levels[b];
        end
        return mask;
    endfunction

    function automatic void add_sample(
        input logic [FIELD_WIDTH-1:0] levels,
        input logic [TIME_WIDTH-1:0]  now
    );
        t_sample s;
        s.levels = levels;
        s.now    = now;
        pending_samples.push_back(s);
    endfunction

    // Mostly held buttons with a steadily advancing clock, plus some noise.
    function automatic void add_random_samples(input int count);
        int roll;
        int step_max;
        step_max = ((timing_now.initial_delay_ms > timing_now.repeat_period_ms) ?
                    timing_now.initial_delay_ms : timing_now.repeat_period_ms) / 4 + 3;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                add_sample(FIELD_WIDTH'($urandom), TIME_WIDTH'($urandom));
            end else begin
                for (int b = 0; b < FIELD_WIDTH; b++) begin
                    if ($urandom_range(99) < 8) begin
                        held_buttons[b] = ~held_buttons[b];
                    end
                end
                if (roll < 12) begin
                    clock_ms = clock_ms + TIME_WIDTH'($urandom);
                end else begin
                    clock_ms = clock_ms + TIME_WIDTH'($urandom_range(0, step_max));
                end
                add_sample(~held_buttons, clock_ms);
            end
        end
    endfunction

    // One register write beat, then the predictor picks up the new value.
    task automatic write_register(
        input logic [INDEX_WIDTH-1:0] index,
        input logic [DELAY_WIDTH-1:0] value
    );
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            CFG_INITIAL_DELAY: timing_now.initial_delay_ms = value;
            CFG_REPEAT_PERIOD: timing_now.repeat_period_ms = value;
            default: ;
        endcase
    endtask

    // Hold off until every sample has gone in and every event beat came out.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_samples.size() != 0 || in_valid || expected_masks.size() != 0);
    endtask

    // Sample driver: predict on each accepted beat, then offer the next one.
    always @(posedge i_clk) begin : drive_samples
        t_sample next_sample;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_masks.push_back(predict_event_mask(button_levels, now_ms));
            end
            if (!in_valid || o_in_ready) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    next_sample   = pending_samples.pop_front();
                    in_valid      <= 1'b1;
                    button_levels <= next_sample.levels;
                    now_ms        <= next_sample.now;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Event monitor: compare each beat with the oldest predicted mask.
    always @(posedge i_clk) begin : check_events
        logic [FIELD_WIDTH-1:0] want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_masks.size() == 0) begin
                    $error("event_mask: expected none, actual %02h", o_event_mask);
                    mismatch_count++;
                end else begin
                    want = expected_masks.pop_front();
                    if (want !== o_event_mask) begin
                        $error("event_mask: expected %02h, actual %02h", want, o_event_mask);
                        mismatch_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: too long without any beat on any channel ends the run.
    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        clear_button_state();
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;

        // Reset timing: press, initial delay edge, repeat edge, release, time wrap.
        @(negedge i_clk);
        add_sample(8'hFF, 32'd0);
        add_sample(8'h00, 32'd0);
        add_sample(8'h00, 32'd299);
        add_sample(8'h00, 32'd300);
        add_sample(8'h00, 32'd399);
        add_sample(8'h00, 32'd400);
        add_sample(8'hFF, 32'd401);
        add_sample(8'h55, 32'hFFFF_FFF0);
        add_sample(8'h55, 32'h0000_0200);
        add_sample(8'hAA, 32'hFFFF_FFFF);
        wait_drained();

        // Zero delay and period: a held button fires on every sample.
        // Writes to unmapped indexes must leave both registers alone.
        write_register(CFG_INITIAL_DELAY, 16'd0);
        write_register(CFG_REPEAT_PERIOD, 16'd0);
        write_register(CFG_UNMAPPED_LOW, 16'h1234);
        write_register(CFG_UNMAPPED_HIGH, 16'hFFFF);
        @(negedge i_clk);
        add_sample(8'h00, 32'd5);
        add_sample(8'h00, 32'd5);
        add_sample(8'h00, 32'd5);
        add_sample(8'hF0, 32'd5);
        add_sample(8'hFF, 32'd6);
        wait_drained();

        // Largest delay and period: the delay probed one below and exactly at it, the period exactly at it.
        write_register(CFG_INITIAL_DELAY, 16'hFFFF);
        write_register(CFG_REPEAT_PERIOD, 16'hFFFF);
        @(negedge i_clk);
        add_sample(8'h00, 32'd1000);
        add_sample(8'h00, 32'd1000 + 32'hFFFE);
        add_sample(8'h00, 32'd1000 + 32'hFFFF);
        add_sample(8'h00, 32'd1000 + 32'h1_FFFE);
        add_sample(8'h7F, 32'd0);
        wait_drained();

        // Random phases, each writing the timing registers and setting a stall pattern.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    write_register(CFG_INITIAL_DELAY, INITIAL_DELAY_RESET);
                    write_register(CFG_REPEAT_PERIOD, REPEAT_PERIOD_RESET);
                    sender_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    write_register(CFG_INITIAL_DELAY, DELAY_WIDTH'($urandom_range(1, 400)));
                    write_register(CFG_REPEAT_PERIOD, DELAY_WIDTH'($urandom_range(1, 200)));
                    sender_idle_pct = 81;
                    stall_pct = 0;
                end
                2: begin
                    write_register(CFG_INITIAL_DELAY, 16'hFFFF);
                    write_register(CFG_REPEAT_PERIOD, 16'hFFFF);
                    sender_idle_pct = 0;
                    stall_pct = 81;
                end
                3: begin
                    write_register(CFG_INITIAL_DELAY, 16'd0);
                    write_register(CFG_REPEAT_PERIOD, 16'd0);
                    sender_idle_pct = 13;
                    stall_pct = 13;
                end
                4: begin
                    write_register(CFG_INITIAL_DELAY, DELAY_WIDTH'($urandom_range(0, 65535)));
                    write_register(CFG_REPEAT_PERIOD, DELAY_WIDTH'($urandom_range(0, 65535)));
                    sender_idle_pct = 0;
                    stall_pct = 0;
                end
                default: begin
                    write_register(CFG_INITIAL_DELAY, 16'd50);
                    write_register(CFG_REPEAT_PERIOD, 16'd0);
                    sender_idle_pct = 81;
                    stall_pct = 81;
                end
            endcase
            @(negedge i_clk);
            add_random_samples(PHASE_SAMPLES);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/btn_rpt_pkg.sv
hdl/btn_rpt_cell.sv
hdl/button_auto_repeat_unit.sv
test/button_auto_repeat_unit_tb.sv
